>>> sv/websocket_frame_deframer_unit_defines.svh
// Assertion macros for the WebSocket deframer.
// Each macro expects a signal named clk and a signal named rst in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define WSD_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("wsd check failed");
`define WSD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsd check failed");
`else
`define WSD_ASSERT_ALWAYS(lbl, expr)
`define WSD_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

>>> sv/wsd_pkg.sv
`default_nettype none
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_LEN16 = 3'd2,
    PH_LEN64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_BODY  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_MSG_END = 3'd1,
    EV_PING    = 3'd2,
    EV_PONG    = 3'd3,
    EV_CLOSE   = 3'd4,
    EV_UNKNOWN = 3'd5
  } event_t;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Last field byte index for each multi-byte header field
  localparam logic [2:0] LAST_LEN16 = 3'd1;
  localparam logic [2:0] LAST_LEN64 = 3'd7;
  localparam logic [2:0] LAST_KEY   = 3'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [3:0] message_type;
    logic       frame_end;
    event_t     event_code;
  } wsd_result_t;

endpackage
`default_nettype wire

>>> sv/wsd_parser.sv
`default_nettype none
module wsd_parser
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = 63
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  in_byte,
  output wsd_result_t      res,
  output logic             res_fire
);

  phase_t                  phase, phase_next;
  logic [2:0]              fcount, fcount_next;
  logic [LENGTH_BITS-1:0]  rlen, rlen_next;
  logic [31:0]             key, key_next;
  logic                    key_present, key_present_next;
  logic [1:0]              key_pos, key_pos_next;
  logic                    frame_final, frame_final_next;
  logic [3:0]              frame_opcode, frame_opcode_next;
  logic [3:0]              msg_opcode, msg_opcode_next;

  logic                    len_done;
  logic                    body_start;
  logic                    close;
  logic                    dv;
  logic [7:0]              d;
  logic [7:0]              key_byte;
  logic [6:0]              len7;
  event_t                  ev;

  assign len7 = in_byte[6:0];

  always_comb begin
    unique case (key_pos)
      2'd0: key_byte = key[31:24];
      2'd1: key_byte = key[23:16];
      2'd2: key_byte = key[15:8];
      2'd3: key_byte = key[7:0];
      default: key_byte = key[7:0];
    endcase
  end

  // Next-state logic: one header or payload byte per step
  always_comb begin
    phase_next        = phase;
    fcount_next       = fcount;
    rlen_next         = rlen;
    key_next          = key;
    key_present_next  = key_present;
    key_pos_next      = key_pos;
    frame_final_next  = frame_final;
    frame_opcode_next = frame_opcode;
    msg_opcode_next   = msg_opcode;
    len_done          = 1'b0;
    body_start        = 1'b0;
    close             = 1'b0;
    dv                = 1'b0;
    d                 = 8'd0;

    unique case (phase)
      PH_HDR1: begin
        key_present_next = in_byte[7];
        fcount_next      = 3'd0;
        key_next         = 32'd0;
        key_pos_next     = 2'd0;
        rlen_next        = '0;
        if (len7 == LEN7_EXT16) begin
          phase_next = PH_LEN16;
        end else if (len7 == LEN7_EXT64) begin
          phase_next = PH_LEN64;
        end else begin
          rlen_next = LENGTH_BITS'(len7);
          len_done  = 1'b1;
        end
      end
      PH_LEN16, PH_LEN64: begin
        rlen_next = {rlen[LENGTH_BITS-9:0], in_byte};
        if (fcount >= ((phase == PH_LEN16) ? LAST_LEN16 : LAST_LEN64)) begin
          len_done = 1'b1;
        end else begin
          fcount_next = fcount + 3'd1;
        end
      end
      PH_KEY: begin
        key_next = {key[23:0], in_byte};
        if (fcount >= LAST_KEY) begin
          fcount_next = 3'd0;
          body_start  = 1'b1;
        end else begin
          fcount_next = fcount + 3'd1;
        end
      end
      PH_BODY: begin
        if (!frame_opcode[3]) begin
          d  = key_present ? (in_byte ^ key_byte) : in_byte;
          dv = 1'b1;
        end
        key_pos_next = key_pos + 2'd1;
        rlen_next    = rlen - LENGTH_BITS'(1);
        close        = (rlen_next == '0);
      end
      default: begin
        frame_final_next  = in_byte[7];
        frame_opcode_next = in_byte[3:0];
        if (in_byte[3:0] != OP_CONT && !in_byte[3]) begin
          msg_opcode_next = in_byte[3:0];
        end
        phase_next = PH_HDR1;
      end
    endcase

    if (len_done) begin
      fcount_next = 3'd0;
      if (key_present_next) begin
        phase_next = PH_KEY;
      end else begin
        body_start = 1'b1;
      end
    end

    if (body_start) begin
      key_pos_next = 2'd0;
      if (rlen_next == '0) begin
        close = 1'b1;
      end else begin
        phase_next = PH_BODY;
      end
    end

    if (close) begin
      phase_next = PH_HDR0;
    end
  end

  // Event reported when a final frame completes
  always_comb begin
    ev = EV_NONE;
    if (close && frame_final) begin
      if (frame_opcode[3]) begin
        unique case (frame_opcode)
          OP_CLOSE: ev = EV_CLOSE;
          OP_PING:  ev = EV_PING;
          OP_PONG:  ev = EV_PONG;
          default:  ev = EV_UNKNOWN;
        endcase
      end else begin
        ev = (msg_opcode == OP_TEXT || msg_opcode == OP_BINARY) ? EV_MSG_END : EV_UNKNOWN;
      end
    end
  end

  assign res.data_byte    = d;
  assign res.data_valid   = dv;
  assign res.message_type = msg_opcode;
  assign res.frame_end    = close;
  assign res.event_code   = ev;
  assign res_fire         = dv | close;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      fcount       <= 3'd0;
      rlen         <= '0;
      key          <= 32'd0;
      key_present  <= 1'b0;
      key_pos      <= 2'd0;
      frame_final  <= 1'b0;
      frame_opcode <= 4'd0;
      msg_opcode   <= 4'd0;
    end else if (step) begin
      phase        <= phase_next;
      fcount       <= fcount_next;
      rlen         <= rlen_next;
      key          <= key_next;
      key_present  <= key_present_next;
      key_pos      <= key_pos_next;
      frame_final  <= frame_final_next;
      frame_opcode <= frame_opcode_next;
      msg_opcode   <= msg_opcode_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/websocket_frame_deframer_unit.sv
// WebSocket (RFC 6455) receive-side deframer. Feed the TCP byte stream one
// item per cycle on the s_ side; the block parses each frame header (FIN,
// opcode, mask bit, 7/16/63-bit length, optional 4-byte masking key), unmasks
// payload bytes of data frames and passes them out at once, and drops the
// payload of control frames. One output item appears for every payload byte
// of a data frame and for every byte that completes a frame (tlast high); a
// final frame also carries an event code in tuser. A continuation frame keeps
// the opcode of the message's first frame. The block sustains one input item
// per clock: the parser state updates in a single pass per byte, and one
// output register holds the result. s_tready stays high while that register
// is empty or being drained, so the input side only stalls when the output
// side does. No clearing pass is needed after reset.
`default_nettype none
`include "websocket_frame_deframer_unit_defines.svh"
module websocket_frame_deframer_unit
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = 63
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input stream
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  // output stream
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] data_byte
  output logic            m_tlast,   // frame_end
  output logic [7:0]      m_tuser    // [0] data_valid, [4:1] message_type, [7:5] event_code
);

  logic        step;
  logic        res_fire;
  wsd_result_t res;
  wsd_result_t res_q;

  // Take a new item whenever the output register is empty or drains this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .in_byte  (s_tdata),
    .res      (res),
    .res_fire (res_fire)
  );

  // Output register: load on a producing item, clear valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= res_fire;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_fire) begin
      res_q <= res;
    end
  end

  assign m_tdata = res_q.data_byte;
  assign m_tlast = res_q.frame_end;
  assign m_tuser = {res_q.event_code, res_q.message_type, res_q.data_valid};

  // An event only ever accompanies the end of a frame
  `WSD_ASSERT_IMPLY(a_event_on_end, m_tvalid && (m_tuser[7:5] != EV_NONE), m_tlast)
  // Every output item carries a payload byte or closes a frame
  `WSD_ASSERT_IMPLY(a_item_has_content, m_tvalid, m_tuser[0] || m_tlast)
  // Data lane is zero when no payload byte is carried
  `WSD_ASSERT_IMPLY(a_idle_data_zero, m_tvalid && !m_tuser[0], m_tdata == 8'd0)

endmodule
`default_nettype wire
